### sv/scope_trigger_column_raster_macros.svh
// Assertion macros for the scope trigger column raster block.
`ifndef SCOPE_TRIGGER_COLUMN_RASTER_MACROS_SVH
`define SCOPE_TRIGGER_COLUMN_RASTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define SCR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SCR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SCR_ASSERT_IMP(name, ante, cons, msg)
`define SCR_ASSERT_NXT(name, ante, cons, msg)

`endif

`endif

### sv/scr_pkg.sv
// Shared types and constants for the scope trigger column raster block.
package scr_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int LEVEL_W   = 12;
  localparam int HYST_W    = 8;
  localparam int COL_W     = 7;
  localparam int NUM_ROWS  = 48;
  localparam int ROW_W     = 6;
  localparam int MASK_W    = NUM_ROWS;
  localparam int LOOKAHEAD = 2;
  localparam int RUN_MAX   = LOOKAHEAD + 1;
  localparam int CNT_W     = $clog2(RUN_MAX + 1);

  // Row = sample / 86 via reciprocal: ceil(2^21 / 86) = 24386, exact for 12-bit samples
  localparam int RECIP_W   = 15;
  localparam int ROW_RECIP = 24386;
  localparam int ROW_SHIFT = 21;
  localparam int PROD_W    = SAMPLE_W + RECIP_W;

  localparam int QUEUE_DEPTH = 4;

  // Config register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_HYSTERESIS = 2'd1;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 12'd2047;
  localparam logic [HYST_W-1:0]  HYST_RESET  = 8'd1;

  // One queued job: the columns caused by one input item
  typedef struct packed {
    logic [RUN_MAX-1:0][SAMPLE_W-1:0] vals;
    logic [CNT_W-1:0]                 cnt;
    logic [COL_W-1:0]                 col0;
    logic                             first;  // vals[0] is column 0 of the frame
    logic                             done;   // last column in job ends the frame
  } scr_job_t;

endpackage

### sv/scr_front.sv
// Front end: config registers, frame tracking, trigger search, job building.
module scr_front #(
  parameter int FRAME_LEN   = 256,
  parameter int NUM_COLUMNS = 128,
  parameter int SEARCH_LEN  = 125
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scr_pkg::LEVEL_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [scr_pkg::SAMPLE_W-1:0]      in_sample,
  output logic                              job_valid,
  input  logic                              job_ready,
  output scr_pkg::scr_job_t                 job
);

  localparam int LA = scr_pkg::LOOKAHEAD;
  localparam int FW = $clog2(FRAME_LEN);
  localparam int CW = $clog2(NUM_COLUMNS + 1);
  localparam int KW = $clog2(FRAME_LEN + SEARCH_LEN + LA + 1);

  logic [scr_pkg::LEVEL_W-1:0]  level_r, level_nxt;
  logic [scr_pkg::HYST_W-1:0]   hyst_r, hyst_nxt;
  logic [FW-1:0]                idx_r, idx_nxt;
  logic [LA-1:0][scr_pkg::SAMPLE_W-1:0] rec_r, rec_nxt;
  logic                         tf_r, tf_nxt;
  logic [CW-1:0]                nc_r, nc_nxt;

  logic [KW-1:0]                k_ext;
  logic                         in_win, runout, hit, settle;
  logic signed [13:0]           lower, upper;
  logic [scr_pkg::CNT_W-1:0]    raw_cnt, n;
  logic [CW-1:0]                avail;
  logic [scr_pkg::RUN_MAX-1:0][scr_pkg::SAMPLE_W-1:0] vals;
  logic                         accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = job_ready;
  assign accept    = in_valid && in_ready;

  assign k_ext  = KW'(idx_r);
  assign in_win = (k_ext >= KW'(LA)) && (k_ext < KW'(SEARCH_LEN + LA));
  assign runout = (k_ext == KW'(SEARCH_LEN + LA - 1));
  assign lower  = $signed({2'b00, level_r}) - $signed({6'b000000, hyst_r});
  assign upper  = $signed({2'b00, level_r}) + $signed({6'b000000, hyst_r});
  assign hit    = ($signed({2'b00, rec_r[0]}) > lower) &&
                  ($signed({2'b00, in_sample}) <= upper);
  assign settle = !tf_r && in_win && (hit || runout);

  // Candidate columns for this item
  always_comb begin
    vals    = '0;
    raw_cnt = '0;
    if (tf_r) begin
      vals[0] = in_sample;
      raw_cnt = scr_pkg::CNT_W'(1);
    end else if (in_win && hit) begin
      for (int j = 0; j < LA; j++) begin
        vals[j] = rec_r[j];
      end
      vals[LA] = in_sample;
      raw_cnt  = scr_pkg::CNT_W'(LA + 1);
    end else if (in_win && runout) begin
      for (int j = 0; j < LA - 1; j++) begin
        vals[j] = rec_r[j + 1];
      end
      vals[LA-1] = in_sample;
      raw_cnt    = scr_pkg::CNT_W'(LA);
    end
  end

  // Clip to the columns still open in this frame
  assign avail = CW'(NUM_COLUMNS) - nc_r;
  assign n = (32'(raw_cnt) > 32'(avail)) ? scr_pkg::CNT_W'(avail) : raw_cnt;

  assign job_valid  = accept && (n != '0);
  assign job.vals   = vals;
  assign job.cnt    = n;
  assign job.col0   = scr_pkg::COL_W'(nc_r);
  assign job.first  = (nc_r == '0);
  assign job.done   = ((32'(nc_r) + 32'(n)) == NUM_COLUMNS);

  always_comb begin
    level_nxt = level_r;
    hyst_nxt  = hyst_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        scr_pkg::REG_TRIGGER_LEVEL:      level_nxt = cfg_data;
        scr_pkg::REG_TRIGGER_HYSTERESIS: hyst_nxt  = cfg_data[scr_pkg::HYST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    rec_nxt = rec_r;
    tf_nxt  = tf_r;
    nc_nxt  = nc_r;
    if (accept) begin
      for (int j = 0; j < LA - 1; j++) begin
        rec_nxt[j] = rec_r[j + 1];
      end
      rec_nxt[LA-1] = in_sample;
      idx_nxt = idx_r + FW'(1);
      if (settle) begin
        tf_nxt = 1'b1;
      end
      nc_nxt = nc_r + CW'(n);
      if (32'(idx_r) == FRAME_LEN - 1) begin
        idx_nxt = '0;
        rec_nxt = '0;
        tf_nxt  = 1'b0;
        nc_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= scr_pkg::LEVEL_RESET;
      hyst_r  <= scr_pkg::HYST_RESET;
      idx_r   <= '0;
      rec_r   <= '0;
      tf_r    <= 1'b0;
      nc_r    <= '0;
    end else begin
      level_r <= level_nxt;
      hyst_r  <= hyst_nxt;
      idx_r   <= idx_nxt;
      rec_r   <= rec_nxt;
      tf_r    <= tf_nxt;
      nc_r    <= nc_nxt;
    end
  end

endmodule

### sv/scr_queue.sv
// Small job queue between front and back ends.
module scr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              push_ready,
  input  scr_pkg::scr_job_t push_job,
  output logic              pop_valid,
  input  logic              pop,
  output scr_pkg::scr_job_t pop_job
);

  localparam int DEPTH = scr_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  scr_pkg::scr_job_t   slots_r [DEPTH];
  logic [PW-1:0]       wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PW:0]         cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign push_ready = (cnt_r != (PW+1)'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = slots_r[rd_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_nxt  = do_push ? wr_r + PW'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + PW'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (PW+1)'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### sv/scr_back.sv
// Back end: unpacks jobs into columns, scales to rows, builds pixel masks.
module scr_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           job_valid,
  output logic                           job_pop,
  input  scr_pkg::scr_job_t              job,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [scr_pkg::COL_W-1:0]      out_column,
  output logic [scr_pkg::MASK_W-1:0]     out_column_mask,
  output logic                           out_last_of_run,
  output logic                           out_frame_done
);

  localparam int NR = scr_pkg::NUM_ROWS;
  localparam int RW = scr_pkg::ROW_W;

  function automatic logic [scr_pkg::MASK_W-1:0] make_mask(
    input logic [RW-1:0] p,
    input logic [RW-1:0] c
  );
    logic [scr_pkg::MASK_W-1:0] m;
    int hi, lo;
    m  = '0;
    hi = (p > c) ? int'(p) : int'(c);
    lo = (p > c) ? int'(c) : int'(p);
    for (int b = 0; b < NR; b++) begin
      if (p == c) begin
        m[b] = (c == '0) ? (b == NR - 1) : (b == NR - hi);
      end else begin
        m[b] = (b >= NR - hi) && (b <= NR - 1 - lo);
      end
    end
    return m;
  endfunction

  logic [scr_pkg::CNT_W-1:0]   sub_r, sub_nxt;
  logic                        take, sub_last;
  logic [scr_pkg::SAMPLE_W-1:0] val;

  // stage A: product registered
  logic                        a_valid_r, a_valid_nxt;
  logic [scr_pkg::PROD_W-1:0]  a_prod_r;
  logic [scr_pkg::COL_W-1:0]   a_col_r;
  logic                        a_first_r, a_last_r, a_done_r;
  logic                        a_ready;

  // stage B: output register
  logic                        out_valid_r, out_valid_nxt;
  logic [scr_pkg::COL_W-1:0]   out_column_r;
  logic [scr_pkg::MASK_W-1:0]  out_column_mask_r;
  logic                        out_last_of_run_r, out_frame_done_r;
  logic                        b_ready, b_load;
  logic [RW-1:0]               prev_row_r, row_raw, row, p_row;

  assign b_ready  = !out_valid_r || out_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign take     = a_ready && job_valid;
  assign sub_last = (sub_r == job.cnt - scr_pkg::CNT_W'(1));
  assign job_pop  = take && sub_last;
  assign val      = job.vals[sub_r];
  assign b_load   = a_valid_r && b_ready;

  assign sub_nxt     = job_pop ? '0 : (take ? sub_r + scr_pkg::CNT_W'(1) : sub_r);
  assign a_valid_nxt = take ? 1'b1 : (b_ready ? 1'b0 : a_valid_r);

  always_ff @(posedge clk) begin
    if (take) begin
      a_prod_r  <= scr_pkg::PROD_W'(val) * scr_pkg::PROD_W'(scr_pkg::ROW_RECIP);
      a_col_r   <= job.col0 + scr_pkg::COL_W'(sub_r);
      a_first_r <= job.first && (sub_r == '0);
      a_last_r  <= sub_last;
      a_done_r  <= job.done && sub_last;
    end
  end

  assign row_raw = a_prod_r[scr_pkg::ROW_SHIFT +: RW];
  assign row     = (32'(row_raw) > NR - 1) ? RW'(NR - 1) : row_raw;
  assign p_row   = a_first_r ? row : prev_row_r;

  assign out_valid_nxt = b_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (b_load) begin
      out_column_r      <= a_col_r;
      out_column_mask_r <= make_mask(p_row, row);
      out_last_of_run_r <= a_last_r;
      out_frame_done_r  <= a_done_r;
      prev_row_r        <= row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= '0;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sub_r       <= sub_nxt;
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_column      = out_column_r;
  assign out_column_mask = out_column_mask_r;
  assign out_last_of_run = out_last_of_run_r;
  assign out_frame_done  = out_frame_done_r;

endmodule

### sv/scope_trigger_column_raster.sv
// Top level of the scope trigger column raster block.
//
//   channel  dir  handshake            payload
//   cfg      in   cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[11:0]
//   in       in   in_valid/in_ready    in_sample[11:0]
//   out      out  out_valid/out_ready  out_column, out_column_mask, out_last_of_run,
//                                      out_frame_done
//
// One input item per clock is accepted while the job queue has room.
// The back end emits one column per clock while out_ready is high; an item
// that resolves the trigger makes up to three columns, which the four-entry
// job queue absorbs. A column passes through the job queue, stage A and the
// output register before it is on the output.
// Reset is synchronous: level 2047, hysteresis 1, frame state cleared.
// A stall on out_ready backs up through the back end into the queue and then
// holds in_ready low; cfg writes are taken in any cycle.
`include "scope_trigger_column_raster_macros.svh"

module scope_trigger_column_raster #(
  parameter int FRAME_LEN   = 256,
  parameter int NUM_COLUMNS = 128,
  parameter int SEARCH_LEN  = 125
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [scr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scr_pkg::LEVEL_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [scr_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [scr_pkg::COL_W-1:0]      out_column,
  output logic [scr_pkg::MASK_W-1:0]     out_column_mask,
  output logic                           out_last_of_run,
  output logic                           out_frame_done
);

  // front -> queue
  logic              push, push_ready;
  scr_pkg::scr_job_t push_job;
  // queue -> back
  logic              q_valid, q_pop;
  scr_pkg::scr_job_t q_job;

  // Front: trigger search and job build
  scr_front #(
    .FRAME_LEN   (FRAME_LEN),
    .NUM_COLUMNS (NUM_COLUMNS),
    .SEARCH_LEN  (SEARCH_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .job_valid (push),
    .job_ready (push_ready),
    .job       (push_job)
  );

  scr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_job    (q_job)
  );

  // Back: row scaling and mask drawing
  scr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (q_valid),
    .job_pop         (q_pop),
    .job             (q_job),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_column      (out_column),
    .out_column_mask (out_column_mask),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done)
  );

  // A column mask always has at least one lit pixel
  `SCR_ASSERT_IMP(a_mask_nonzero, out_valid, out_column_mask != '0, "empty column mask")
  // The frame's last column ends its item's run
  `SCR_ASSERT_IMP(a_done_last, out_valid && out_frame_done, out_last_of_run, "frame_done not last")
  // Column 0 joins to itself: exactly one pixel
  `SCR_ASSERT_IMP(a_col0_onehot, out_valid && out_column == '0 && NUM_COLUMNS <= 128,
    $onehot(out_column_mask), "column 0 mask not one pixel")

endmodule

### bench/raster_check_pkg.sv
// Column predictor and result scoreboard for the scope trigger column raster bench.
`timescale 1ns / 1ps

package raster_check_pkg;
  import scr_pkg::*;

  localparam int FRAME_SAMPLES = 256;
  localparam int COLUMNS       = 128;
  localparam int SEARCH_SPAN   = 125;
  localparam int ROW_DIV       = 86;

  // indexes the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  typedef struct {
    logic [COL_W-1:0]  column;
    logic [MASK_W-1:0] mask;
    logic              last;
    logic              done;
  } column_t;

  class raster_scoreboard;
    logic [LEVEL_W-1:0]  level;
    logic [HYST_W-1:0]   hyst;
    int unsigned         pos;
    logic [SAMPLE_W-1:0] held [LOOKAHEAD];
    bit                  settled;
    int unsigned         col_next;
    int unsigned         row_prev;
    column_t             column_q [$];
    int unsigned         errors;

    function new();
      level  = LEVEL_RESET;
      hyst   = HYST_RESET;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos      = 0;
      settled  = 0;
      col_next = 0;
      row_prev = 0;
      foreach (held[j]) held[j] = '0;
    endfunction

    function int unsigned outstanding();
      return column_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] data);
      case (idx)
        REG_TRIGGER_LEVEL:      level = data;
        REG_TRIGGER_HYSTERESIS: hyst  = data[HYST_W-1:0];
        default: ;
      endcase
    endfunction

    // Scale one sample to a row and queue the mask joining it to the previous row.
    function void push_column(logic [SAMPLE_W-1:0] v);
      int unsigned row, hi, lo;
      logic [63:0] wide;
      column_t c;
      if (col_next >= COLUMNS) return;
      row = v / ROW_DIV;
      if (row > NUM_ROWS - 1) row = NUM_ROWS - 1;
      if (col_next == 0) row_prev = row;
      if (row_prev == row) begin
        wide = 64'd1 << ((row == 0) ? NUM_ROWS - 1 : NUM_ROWS - row);
      end else begin
        hi   = (row_prev > row) ? row_prev : row;
        lo   = (row_prev > row) ? row : row_prev;
        wide = ((64'd1 << (hi - lo)) - 64'd1) << (NUM_ROWS - hi);
      end
      c.column = col_next[COL_W-1:0];
      c.mask   = wide[MASK_W-1:0];
      c.last   = 1'b0;
      c.done   = (col_next == COLUMNS - 1);
      column_q.push_back(c);
      row_prev = row;
      col_next++;
    endfunction

    // One accepted sample: trigger search, then column emission.
    function void note_sample(logic [SAMPLE_W-1:0] v);
      int lower, upper, first;
      int unsigned made;
      bit fire;
      made = column_q.size();
      if (!settled) begin
        if (pos >= LOOKAHEAD && pos - LOOKAHEAD < SEARCH_SPAN) begin
          lower = int'(level) - int'(hyst);
          upper = int'(level) + int'(hyst);
          fire  = (int'(held[0]) > lower) && (int'(v) <= upper);
          if (fire || pos - LOOKAHEAD == SEARCH_SPAN - 1) begin
            // search ran out: trigger point is one past the oldest held sample
            first   = fire ? 0 : 1;
            settled = 1;
            for (int j = first; j < LOOKAHEAD; j++) push_column(held[j]);
            push_column(v);
          end
        end
      end else begin
        push_column(v);
      end
      for (int j = 0; j + 1 < LOOKAHEAD; j++) held[j] = held[j + 1];
      held[LOOKAHEAD - 1] = v;
      pos++;
      if (pos >= FRAME_SAMPLES) clear_frame();
      if (column_q.size() > made) column_q[$].last = 1'b1;
    endfunction

    function void check_result(logic [COL_W-1:0] col, logic [MASK_W-1:0] mask,
                               logic last, logic done);
      column_t want;
      if (column_q.size() == 0) begin
        $error("unexpected column %0d mask %h", col, mask);
        errors++;
        return;
      end
      want = column_q.pop_front();
      if (col !== want.column) begin
        $error("column: expected %0d, got %0d", want.column, col);
        errors++;
      end
      if (mask !== want.mask) begin
        $error("column_mask: expected %h, got %h", want.mask, mask);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0b, got %0b", want.last, last);
        errors++;
      end
      if (done !== want.done) begin
        $error("frame_done: expected %0b, got %0b", want.done, done);
        errors++;
      end
    endfunction
  endclass

endpackage

### bench/tb_scope_trigger_column_raster.sv
// Top-level bench: drives sample frames and register writes, checks every column.
`timescale 1ns / 1ps

module tb_scope_trigger_column_raster;
  import scr_pkg::*;
  import raster_check_pkg::*;

  localparam int DRAIN_CYCLES = 16;      // well past the job queue, stage A and the output register
  localparam int CYCLE_LIMIT  = 200000;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [LEVEL_W-1:0]    cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_sample   = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [COL_W-1:0]      out_column;
  logic [MASK_W-1:0]     out_column_mask;
  logic                  out_last_of_run;
  logic                  out_frame_done;

  raster_scoreboard sb = new();

  // gap modes, redrawn every 64 items so that gap-free stretches occur too
  bit          tx_gaps    = 1'b0;
  bit          rx_gaps    = 1'b0;
  int unsigned sent_total = 0;
  int unsigned rx_hold    = 0;
  int unsigned cycle_count = 0;
  logic [SAMPLE_W-1:0] last_wave = '0;

  // sent right after the trigger point of frame 0: row boundaries
  // (85/86, 4041/4042), full-scale swings and flat runs
  logic [SAMPLE_W-1:0] boundary_codes [20] = '{
    12'd0,    12'd4095, 12'd4095, 12'd0,    12'd0,
    12'd85,   12'd86,   12'd4042, 12'd4041, 12'd2048,
    12'd2047, 12'd2046, 12'd172,  12'd171,  12'd4095,
    12'd0,    12'hAAA,  12'h555,  12'd1,    12'd4094
  };

  scope_trigger_column_raster dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_column      (out_column),
    .out_column_mask (out_column_mask),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: check each accepted column, then, when stalls are enabled,
  // hold ready low until a random countdown has run out.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_column, out_column_mask, out_last_of_run, out_frame_done);
      rx_hold = rx_gaps ? $urandom_range(0, 4) : 0;
    end else if (rx_hold > 0) begin
      rx_hold--;
    end
    out_ready <= (rx_hold == 0);
  end

  // Watchdog: a hang or a lost column ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Waveform-like sample source: uniform draws, with small steps, repeats,
  // row-boundary codes and a low band so equal-row and short masks show up.
  function automatic logic [SAMPLE_W-1:0] next_wave(logic [SAMPLE_W-1:0] prev);
    int step;
    case ($urandom_range(0, 7))
      0, 1, 2: return SAMPLE_W'($urandom_range(0, 4095));
      3, 4: begin
        step = int'($urandom_range(0, 240)) - 120;
        if (int'(prev) + step < 0) return '0;
        if (int'(prev) + step > 4095) return 12'd4095;
        return SAMPLE_W'(int'(prev) + step);
      end
      5: return prev;
      6: begin
        case ($urandom_range(0, 4))
          0: return 12'd0;
          1: return 12'd4095;
          2: return 12'd85;
          3: return 12'd86;
          default: return 12'd4042;
        endcase
      end
      default: return SAMPLE_W'($urandom_range(0, 171));
    endcase
  endfunction

  // Valid is only lowered when a gap is drawn, so back-to-back items keep it
  // high without a second assignment in the same step.
  task automatic send_sample(input logic [SAMPLE_W-1:0] v);
    int unsigned gap;
    if (sent_total % 64 == 0) begin
      tx_gaps = ($urandom_range(0, 2) != 0);
      rx_gaps = ($urandom_range(0, 2) != 0);
    end
    gap = tx_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(v);
    sent_total++;
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) begin
      last_wave = next_wave(last_wave);
      send_sample(last_wave);
    end
  endtask

  // Batched writes keep valid high; the caller drops it after the last one.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Sender stops until every expected column has come out, then lets the
  // pipeline settle (tail samples make no column but still pass through).
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Frame 0: reset values (level 2047, hysteresis 1). Every search sample
    // sits at or below 2046, so the search runs out and the last held sample and
    // the current one come out together; boundary codes and random samples follow.
    repeat (SEARCH_SPAN + LOOKAHEAD) send_sample(SAMPLE_W'($urandom_range(0, 2046)));
    foreach (boundary_codes[j]) send_sample(boundary_codes[j]);
    send_random(FRAME_SAMPLES - SEARCH_SPAN - LOOKAHEAD - 20);
    drain();

    // Frame 1: level 0, hysteresis 255 -> lower bound negative, so the first
    // half of the test always passes. The hysteresis write carries upper bits
    // that must be masked off; unused indexes must be ignored. Samples stay
    // above 255 until the last search position, so three columns come out there.
    cfg_write(REG_TRIGGER_LEVEL, 12'h000);
    cfg_write(REG_TRIGGER_HYSTERESIS, 12'hFFF);
    cfg_write(REG_UNUSED_2, LEVEL_W'($urandom_range(0, 4095)));
    cfg_write(REG_UNUSED_3, LEVEL_W'($urandom_range(0, 4095)));
    cfg_valid <= 1'b0;
    repeat (SEARCH_SPAN + LOOKAHEAD - 1) send_sample(SAMPLE_W'($urandom_range(256, 4095)));
    send_sample(12'd0);
    send_random(1);
    drain();

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/scr_pkg.sv
sv/scr_front.sv
sv/scr_queue.sv
sv/scr_back.sv
sv/scope_trigger_column_raster.sv
bench/raster_check_pkg.sv
bench/tb_scope_trigger_column_raster.sv
